FILE: design/ar_process_filter_top_defines.svh
// assertion macros shared by the filter rtl
`ifndef AR_PROCESS_FILTER_TOP_DEFINES_SVH
`define AR_PROCESS_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define ARPF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arpf assertion failed");

// next-cycle implication, checked on clk, off during rst
`define ARPF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arpf assertion failed");

`endif

FILE: design/arpf_pkg.sv
// shared types, constants and helpers for the autoregressive filter
package arpf_pkg;

  localparam int MAX_ORDER    = 6;
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEFF_WIDTH  = 16;
  localparam int COEFF_FRAC   = 14;
  localparam int ORDER_WIDTH  = 3;
  localparam int COUNT_WIDTH  = 16;

  localparam int TAP_WIDTH    = $clog2(MAX_ORDER);
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEFF_WIDTH;
  // noise plus MAX_ORDER scaled products, with headroom
  localparam int ACC_WIDTH    = PROD_WIDTH - COEFF_FRAC + $clog2(MAX_ORDER + 1) + 1;

  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 16;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEFF_WIDTH-1:0]  coeff_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic [TAP_WIDTH-1:0]           tap_t;
  typedef logic [ORDER_WIDTH-1:0]         order_t;
  typedef logic [CFG_IDX_WIDTH-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_WIDTH-1:0]      cfg_data_t;

  localparam cfg_idx_t REG_ORDER   = cfg_idx_t'(0);
  localparam cfg_idx_t REG_DISCARD = cfg_idx_t'(1);
  localparam cfg_idx_t REG_COEFF0  = cfg_idx_t'(2);
  localparam cfg_idx_t REG_COEFF1  = cfg_idx_t'(3);
  localparam cfg_idx_t REG_COEFF2  = cfg_idx_t'(4);
  localparam cfg_idx_t REG_COEFF3  = cfg_idx_t'(5);
  localparam cfg_idx_t REG_COEFF4  = cfg_idx_t'(6);
  localparam cfg_idx_t REG_COEFF5  = cfg_idx_t'(7);

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controls for the shared multiply-accumulate unit
  typedef struct packed {
    logic load;   // start a new sum from the noise sample
    logic issue;  // multiply the selected tap this cycle
  } mac_ctrl_t;

  // zero acts as one pole, anything above the tap count as all taps
  function automatic order_t clamp_order(input order_t ord);
    order_t res;
    res = ord;
    if (ord == '0) begin
      res = order_t'(1);
    end else if (ord > order_t'(MAX_ORDER)) begin
      res = order_t'(MAX_ORDER);
    end
    return res;
  endfunction

endpackage

FILE: design/arpf_noise_if.sv
// input channel carrying one driving noise sample
interface arpf_noise_if;
  logic                     valid;
  logic                     ready;
  arpf_pkg::sample_t        noise_sample;

  modport source (output valid, output noise_sample, input ready);
  modport sink   (input valid, input noise_sample, output ready);
endinterface

FILE: design/arpf_result_if.sv
// output channel carrying one filter result
interface arpf_result_if;
  logic                     valid;
  logic                     ready;
  arpf_pkg::sample_t        sample;
  logic                     saturated;

  modport source (output valid, output sample, output saturated, input ready);
  modport sink   (input valid, input sample, input saturated, output ready);
endinterface

FILE: design/arpf_cfg_if.sv
// register write channel
interface arpf_cfg_if;
  logic                     valid;
  logic                     ready;
  arpf_pkg::cfg_idx_t       index;
  arpf_pkg::cfg_data_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/arpf_mac.sv
// shared multiply-accumulate unit: one tap product per cycle, added to the sum in the next cycle
module arpf_mac (
  input  logic                clk,
  input  logic                rst,
  input  arpf_pkg::mac_ctrl_t ctrl,
  input  arpf_pkg::sample_t   noise_sample,
  input  arpf_pkg::coeff_t    coeff,
  input  arpf_pkg::sample_t   hist,
  output arpf_pkg::acc_t      acc
);

  arpf_pkg::prod_t                        prod;
  logic                                   prod_vld;
  arpf_pkg::acc_t                         acc_next;

  always_comb begin
    acc_next = acc;
    if (ctrl.load) begin
      acc_next = arpf_pkg::acc_t'(noise_sample);
    end else if (prod_vld) begin
      // floor shift of each product before it joins the sum
      acc_next = acc + arpf_pkg::acc_t'(prod >>> arpf_pkg::COEFF_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.issue && !ctrl.load;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (ctrl.issue) begin
      prod <= arpf_pkg::prod_t'(coeff) * arpf_pkg::prod_t'(hist);
    end
  end

endmodule

FILE: design/ar_process_filter_top.sv
// autoregressive all-pole filter with one shared multiply-accumulate unit
// order clamped to 1..6
// one sample at a time, set by the single multiplier stepping over the history
//   taps; ready is high only between samples
// a full output register stalls the finish step until the result is taken
// rst (sync, active high) clears history, coeffs, transient count; order resets to 1
`include "ar_process_filter_top_defines.svh"

module ar_process_filter_top (
  input  logic           clk,
  input  logic           rst,
  arpf_noise_if.sink     noise,
  arpf_result_if.source  result,
  arpf_cfg_if.sink       cfg
);

  arpf_pkg::state_t  state, state_next;
  arpf_pkg::tap_t    tap, tap_next;
  arpf_pkg::order_t  order;
  arpf_pkg::order_t  n_eff;
  logic [arpf_pkg::COUNT_WIDTH-1:0] transient_left;
  arpf_pkg::coeff_t  coeff [arpf_pkg::MAX_ORDER];
  arpf_pkg::sample_t history [arpf_pkg::MAX_ORDER];

  arpf_pkg::mac_ctrl_t mac_ctrl;
  arpf_pkg::acc_t      acc;
  arpf_pkg::sample_t   sat_value;
  logic                sat_flag;
  logic                finish;
  logic                emit;
  logic                out_valid;
  arpf_pkg::sample_t   out_sample;
  logic                out_sat;

  assign n_eff = arpf_pkg::clamp_order(order);

  arpf_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (mac_ctrl),
    .noise_sample (noise.noise_sample),
    .coeff        (coeff[tap]),
    .hist         (history[tap]),
    .acc          (acc)
  );

  // saturate the finished sum to the sample range
  always_comb begin
    sat_value = arpf_pkg::sample_t'(acc);
    sat_flag  = 1'b0;
    if (acc > arpf_pkg::acc_t'(arpf_pkg::SAMPLE_MAX)) begin
      sat_value = arpf_pkg::SAMPLE_MAX;
      sat_flag  = 1'b1;
    end else if (acc < arpf_pkg::acc_t'(arpf_pkg::SAMPLE_MIN)) begin
      sat_value = arpf_pkg::SAMPLE_MIN;
      sat_flag  = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    tap_next   = tap;
    unique case (state)
      arpf_pkg::ST_IDLE: begin
        if (noise.valid) begin
          state_next = arpf_pkg::ST_MAC;
          tap_next   = '0;
        end
      end
      arpf_pkg::ST_MAC: begin
        tap_next = tap + arpf_pkg::tap_t'(1);
        if (arpf_pkg::order_t'(tap) == n_eff - arpf_pkg::order_t'(1)) begin
          state_next = arpf_pkg::ST_DRAIN;
          tap_next   = tap;
        end
      end
      arpf_pkg::ST_DRAIN: begin
        state_next = arpf_pkg::ST_DONE;
      end
      arpf_pkg::ST_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = arpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = arpf_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    noise.ready    = 1'b0;
    mac_ctrl.load  = 1'b0;
    mac_ctrl.issue = 1'b0;
    finish         = 1'b0;
    unique case (state)
      arpf_pkg::ST_IDLE: begin
        noise.ready   = 1'b1;
        mac_ctrl.load = noise.valid;
      end
      arpf_pkg::ST_MAC: begin
        mac_ctrl.issue = 1'b1;
      end
      arpf_pkg::ST_DRAIN: begin
      end
      arpf_pkg::ST_DONE: begin
        finish = !out_valid || result.ready;
      end
      default: begin
      end
    endcase
  end

  assign emit = finish && (transient_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arpf_pkg::ST_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

  // configuration registers and transient counter
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order          <= arpf_pkg::order_t'(1);
      transient_left <= '0;
      for (int i = 0; i < arpf_pkg::MAX_ORDER; i++) begin
        coeff[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index) inside
          arpf_pkg::REG_ORDER: begin
            order <= cfg.data[arpf_pkg::ORDER_WIDTH-1:0];
          end
          arpf_pkg::REG_COEFF0, arpf_pkg::REG_COEFF1, arpf_pkg::REG_COEFF2,
          arpf_pkg::REG_COEFF3, arpf_pkg::REG_COEFF4, arpf_pkg::REG_COEFF5: begin
            coeff[arpf_pkg::tap_t'(cfg.index - arpf_pkg::REG_COEFF0)] <=
              arpf_pkg::coeff_t'(cfg.data);
          end
          default: begin
          end
        endcase
      end
      // a discard count write restarts the discard phase
      if (cfg.valid && cfg.index == arpf_pkg::REG_DISCARD) begin
        transient_left <= cfg.data[arpf_pkg::COUNT_WIDTH-1:0];
      end else if (finish && transient_left != '0) begin
        transient_left <= transient_left - 1'b1;
      end
    end
  end

  // history shift line, newest output at the head
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < arpf_pkg::MAX_ORDER; i++) begin
        history[i] <= '0;
      end
    end else if (finish) begin
      history[0] <= sat_value;
      for (int i = 1; i < arpf_pkg::MAX_ORDER; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample <= sat_value;
      out_sat    <= sat_flag;
    end
  end

  assign result.valid     = out_valid;
  assign result.sample    = out_sample;
  assign result.saturated = out_sat;

  `ARPF_ASSERT_NXT(a_accept_starts_mac, noise.valid && noise.ready, state == arpf_pkg::ST_MAC)
  `ARPF_ASSERT_IMP(a_tap_in_order, state == arpf_pkg::ST_MAC, arpf_pkg::order_t'(tap) < n_eff)
  `ARPF_ASSERT_NXT(a_done_waits, state == arpf_pkg::ST_DONE && out_valid && !result.ready, state == arpf_pkg::ST_DONE)
  `ARPF_ASSERT_IMP(a_sat_at_rail, result.valid && result.saturated, result.sample == arpf_pkg::SAMPLE_MAX || result.sample == arpf_pkg::SAMPLE_MIN)

endmodule
